[rtl/core/fenwick_2d_region_sum_assert.svh]
// assertion macros shared by the fenwick region sum modules
`ifndef FENWICK_2D_REGION_SUM_ASSERT_SVH
`define FENWICK_2D_REGION_SUM_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define FEN2D_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fen2d assertion failed");

// next-cycle implication
`define FEN2D_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fen2d assertion failed");

`endif

[rtl/core/fen2d_pkg.sv]
// shared types and codes for the fenwick region sum block
`timescale 1ns / 1ps
package fen2d_pkg;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic init_walk;
    logic rd;
    logic apply;
    logic next_corner;
    logic out_load;
  } fen2d_cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic clr_done;
    logic is_query;
    logic walk_done;
    logic last_corner;
    logic out_free;
  } fen2d_sts_t;

endpackage

[rtl/core/fen2d_ctrl.sv]
// sequencer for clear pass, update walk and four-corner query walk
`timescale 1ns / 1ps
`include "fenwick_2d_region_sum_assert.svh"
module fen2d_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  fen2d_pkg::fen2d_sts_t sts,
  output fen2d_pkg::fen2d_cmd_t cmd
);
  import fen2d_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SETUP = 6'b000100,
    ST_READ  = 6'b001000,
    ST_USE   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.init_walk = 1'b1;
        state_next    = ST_READ;
      end
      ST_READ: begin
        if (sts.walk_done) begin
          if (!sts.is_query) begin
            state_next = ST_IDLE;
          end else if (sts.last_corner) begin
            state_next = ST_EMIT;
          end else begin
            cmd.next_corner = 1'b1;
            state_next      = ST_SETUP;
          end
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_USE;
        end
      end
      ST_USE: begin
        cmd.apply  = 1'b1;
        state_next = ST_READ;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // read data is only consumed the cycle after it was requested
  `FEN2D_ASSERT_IMP(a_use_after_read, state == ST_USE, $past(state) == ST_READ)
  // a result only moves into the output register when it has room
  `FEN2D_ASSERT_IMP(a_emit_has_room, cmd.out_load, sts.out_free && sts.is_query)

endmodule

[rtl/core/fen2d_dp.sv]
// tree memory, walk indices, accumulator and output register
`timescale 1ns / 1ps
`include "fenwick_2d_region_sum_assert.svh"
module fen2d_dp #(
  parameter int GRID = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fen2d_pkg::fen2d_cmd_t cmd,
  output fen2d_pkg::fen2d_sts_t sts,
  input  logic                  opcode,
  input  logic [3:0]            top_row,
  input  logic [3:0]            left_col,
  input  logic [3:0]            bottom_row,
  input  logic [3:0]            right_col,
  input  logic signed [31:0]    add_value,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic signed [31:0]    region_sum
);
  import fen2d_pkg::*;

  localparam int CW    = $clog2(2 * GRID + 1);
  localparam int EW    = (CW > 5) ? CW : 5;
  localparam int CELLS = GRID * GRID;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [31:0]   mem [CELLS];
  logic [31:0]   rd_data;

  logic          op_q;
  logic [3:0]    r1_q, c1_q, r2_q, c2_q;
  logic [31:0]   amt_q;
  logic          skip_q;
  logic [1:0]    k_q;
  logic [CW-1:0] i_q, j_q, jbase_q;
  logic [31:0]   acc;
  logic [AW-1:0] clr_cnt;

  logic          is_query;
  logic [EW-1:0] row_cnt, col_cnt;
  logic [CW-1:0] row_sat, col_sat, upd_i, upd_j;
  logic [CW-1:0] low_i, low_j, j_dn, j_up;
  logic [AW-1:0] node_addr, wr_addr;
  logic          wr_en;
  logic [31:0]   wr_data;
  logic          walk_done, out_free;

  assign is_query = (op_q == OP_QUERY);

  // corners 1 and 3 take the first row, corners 2 and 3 the first column
  assign row_cnt = k_q[0] ? EW'(r1_q) : EW'(r2_q) + EW'(1);
  assign col_cnt = k_q[1] ? EW'(c1_q) : EW'(c2_q) + EW'(1);
  assign row_sat = (row_cnt > EW'(GRID)) ? CW'(GRID) : CW'(row_cnt);
  assign col_sat = (col_cnt > EW'(GRID)) ? CW'(GRID) : CW'(col_cnt);
  assign upd_i   = CW'(EW'(r1_q) + EW'(1));
  assign upd_j   = CW'(EW'(c1_q) + EW'(1));

  assign low_i = i_q & (~i_q + CW'(1));
  assign low_j = j_q & (~j_q + CW'(1));
  assign j_dn  = j_q - low_j;
  assign j_up  = j_q + low_j;

  assign walk_done = is_query ? ((i_q == '0) || (j_q == '0))
                              : (skip_q || (i_q > CW'(GRID)));

  assign node_addr = AW'(AW'(i_q - CW'(1)) * AW'(GRID) + AW'(j_q - CW'(1)));
  assign wr_en     = cmd.clr_step || (cmd.apply && !is_query);
  assign wr_addr   = cmd.clr_step ? clr_cnt : node_addr;
  assign wr_data   = cmd.clr_step ? 32'd0 : rd_data + amt_q;

  assign out_free = !out_valid || !out_stall;

  assign sts.clr_done    = (clr_cnt == AW'(CELLS - 1));
  assign sts.is_query    = is_query;
  assign sts.walk_done   = walk_done;
  assign sts.last_corner = (k_q == 2'd3);
  assign sts.out_free    = out_free;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) rd_data <= mem[node_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_cnt <= clr_cnt + AW'(1);
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= opcode;
      r1_q   <= top_row;
      c1_q   <= left_col;
      r2_q   <= bottom_row;
      c2_q   <= right_col;
      amt_q  <= $unsigned(add_value);
      skip_q <= (EW'(top_row) >= EW'(GRID)) || (EW'(left_col) >= EW'(GRID));
      k_q    <= 2'd0;
      acc    <= 32'd0;
    end
    if (cmd.next_corner) k_q <= k_q + 2'd1;
    if (cmd.init_walk) begin
      if (is_query) begin
        i_q     <= row_sat;
        j_q     <= col_sat;
        jbase_q <= col_sat;
      end else begin
        i_q     <= upd_i;
        j_q     <= upd_j;
        jbase_q <= upd_j;
      end
    end
    if (cmd.apply) begin
      if (is_query) begin
        // corners 1 and 2 are subtracted
        acc <= (k_q[0] ^ k_q[1]) ? acc - rd_data : acc + rd_data;
        if (j_dn == '0) begin
          j_q <= jbase_q;
          i_q <= i_q - low_i;
        end else begin
          j_q <= j_dn;
        end
      end else begin
        if (j_up > CW'(GRID)) begin
          j_q <= jbase_q;
          i_q <= i_q + low_i;
        end else begin
          j_q <= j_up;
        end
      end
    end
    if (cmd.out_load) region_sum <= $signed(acc);
  end

  // updates never write a node outside the grid
  `FEN2D_ASSERT_IMP(a_write_in_grid, cmd.apply && !is_query, !walk_done)
  // nothing is offered while the tree is still being cleared
  `FEN2D_ASSERT_IMP(a_no_result_in_clear, cmd.clr_step, !out_valid)

endmodule

[rtl/core/fenwick_2d_region_sum.sv]
// top level of the two-dimensional fenwick tree region sum block
`timescale 1ns / 1ps
// two-dimensional binary indexed tree over a GRID x GRID grid of 32-bit
// cells. an item with opcode add puts add_value into cell (top_row, left_col)
// and gives no result; a cell outside the grid leaves the tree unchanged.
// an item with opcode query gives one result, the sum over rows top_row..
// bottom_row and columns left_col..right_col, formed from four corner
// prefix sums; corners past the grid saturate to its edge and a reversed
// rectangle is not checked. all sums wrap at 32 bits two's complement.
// after reset the tree memory is cleared one cell a cycle, all GRID*GRID
// cells (256 at the default size), during which no item is taken. every
// tree node is read from the tree memory, then added to and written back
// (update) or accumulated (query). an update visits N nodes, with N the
// product of the row and column chain lengths (at most 25 at GRID 16); a
// query walks its four corners in turn and may then wait for room in the
// output register. a finished result waits in an output register, so the
// next item is accepted while the result is still stalled.
module fenwick_2d_region_sum #(
  parameter int GRID = 16
) (
  input  logic               clk,
  input  logic               rst,
  // input item channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [3:0]         top_row,
  input  logic [3:0]         left_col,
  input  logic [3:0]         bottom_row,
  input  logic [3:0]         right_col,
  input  logic signed [31:0] add_value,
  // result item channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] region_sum
);
  import fen2d_pkg::*;

  fen2d_cmd_t cmd;
  fen2d_sts_t sts;

  // sequencer: clear pass, item capture, node walk, result hand-off
  fen2d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // tree memory, walk indices, accumulator and output register
  fen2d_dp #(
    .GRID (GRID)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (opcode),
    .top_row    (top_row),
    .left_col   (left_col),
    .bottom_row (bottom_row),
    .right_col  (right_col),
    .add_value  (add_value),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .region_sum (region_sum)
  );

endmodule

[sim/fenwick_2d_region_sum_tb.sv]
// self-checking testbench for the two-dimensional fenwick region sum block
`timescale 1ns / 1ps
module fenwick_2d_region_sum_tb;
  import fen2d_pkg::*;

  localparam int GRID_N       = 16;
  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int QUIET_LIMIT  = 5000;

  typedef struct {
    logic               op;
    logic [3:0]         r1;
    logic [3:0]         c1;
    logic [3:0]         r2;
    logic [3:0]         c2;
    logic signed [31:0] amount;
  } region_item_t;

  // mirror of the tree plus the queue of region sums still owed by the block
  class region_sum_board;
    bit [31:0]          tree [GRID_N][GRID_N];
    logic signed [31:0] sums_due [$];
    int                 mismatches;

    function new();
      foreach (tree[i, j]) tree[i][j] = '0;
      mismatches = 0;
    endfunction

    // sum over the first rows x cols cells, counts clipped to the grid
    function bit [31:0] corner_sum(int rows, int cols);
      bit [31:0] acc;
      int        i;
      int        j;
      acc = '0;
      if (rows > GRID_N) rows = GRID_N;
      if (cols > GRID_N) cols = GRID_N;
      for (i = rows; i > 0; i -= i & -i)
        for (j = cols; j > 0; j -= j & -j)
          acc += tree[i - 1][j - 1];
      return acc;
    endfunction

    function void note_item(logic op, int r1, int c1, int r2, int c2, logic [31:0] amount);
      int i;
      int j;
      if (op == OP_ADD) begin
        // cells off the grid leave the tree alone
        if (r1 < GRID_N && c1 < GRID_N) begin
          for (i = r1 + 1; i <= GRID_N; i += i & -i)
            for (j = c1 + 1; j <= GRID_N; j += j & -j)
              tree[i - 1][j - 1] += amount;
        end
      end else begin
        // inclusion-exclusion, no check on the rectangle order
        sums_due.push_back(corner_sum(r2 + 1, c2 + 1) - corner_sum(r1, c2 + 1)
                           - corner_sum(r2 + 1, c1) + corner_sum(r1, c1));
      end
    endfunction

    function void check_sum(logic signed [31:0] got);
      logic signed [31:0] want;
      if (sums_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("region_sum %0d with no query outstanding", got);
      end else begin
        want = sums_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("region_sum mismatch: expected %0d, got %0d", want, got);
        end
      end
    endfunction

    function int pending();
      return sums_due.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               opcode;
  logic [3:0]         top_row;
  logic [3:0]         left_col;
  logic [3:0]         bottom_row;
  logic [3:0]         right_col;
  logic signed [31:0] add_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] region_sum;

  region_sum_board sb = new();
  bit              calm;
  bit              hold_req;

  fenwick_2d_region_sum #(
    .GRID(GRID_N)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .top_row   (top_row),
    .left_col  (left_col),
    .bottom_row(bottom_row),
    .right_col (right_col),
    .add_value (add_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .region_sum(region_sum)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // results are checked before the same edge's input is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_sum(region_sum);
      if (in_valid && !in_stall)
        sb.note_item(opcode, int'(top_row), int'(left_col), int'(bottom_row),
                     int'(right_col), add_value);
    end
  end

  // receiver: random stalls, a quiet window, and one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 15);
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("** fenwick_2d_region_sum: FAILED **");
    $finish;
  end

  function automatic region_item_t add_at(int r, int c, logic [31:0] v);
    region_item_t it;
    it.op     = OP_ADD;
    it.r1     = 4'(r);
    it.c1     = 4'(c);
    it.r2     = ~it.r1;
    it.c2     = ~it.c1;
    it.amount = v;
    return it;
  endfunction

  function automatic region_item_t query_box(int r1, int c1, int r2, int c2);
    region_item_t it;
    it.op     = OP_QUERY;
    it.r1     = 4'(r1);
    it.c1     = 4'(c1);
    it.r2     = 4'(r2);
    it.c2     = 4'(c2);
    it.amount = 32'h5a5a_a5a5;
    return it;
  endfunction

  function automatic region_item_t random_item();
    region_item_t it;
    logic [3:0]   a;
    logic [3:0]   b;
    int           pick;
    it.r1     = 4'($urandom);
    it.c1     = 4'($urandom);
    it.r2     = 4'($urandom);
    it.c2     = 4'($urandom);
    it.amount = $urandom;
    pick      = $urandom_range(9);
    if ($urandom_range(1) == 0) begin
      it.op = OP_ADD;
      if (pick == 0) it.amount = $signed($urandom_range(20)) - 10;
      else if (pick == 1) begin
        case ($urandom_range(3))
          0: it.amount = 32'h7fff_ffff;
          1: it.amount = 32'h8000_0000;
          2: it.amount = -1;
          default: it.amount = 0;
        endcase
      end
    end else begin
      it.op = OP_QUERY;
      if (pick < 7) begin
        // well-formed rectangle
        a = 4'($urandom); b = 4'($urandom);
        it.r1 = (a < b) ? a : b;
        it.r2 = (a < b) ? b : a;
        a = 4'($urandom); b = 4'($urandom);
        it.c1 = (a < b) ? a : b;
        it.c2 = (a < b) ? b : a;
      end else if (pick == 9) begin
        // strip touching row zero and the last column
        it.r1 = 4'd0;
        it.c2 = 4'(GRID_N - 1);
      end
    end
    return it;
  endfunction

  // offer one item, idling first at random, and wait for it to be taken
  task automatic send_item(input region_item_t it);
    while (!calm && $urandom_range(99) < 15) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    opcode     <= it.op;
    top_row    <= it.r1;
    left_col   <= it.c1;
    bottom_row <= it.r2;
    right_col  <= it.c2;
    add_value  <= it.amount;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
  endtask

  initial begin : stimulus
    int n;
    rst        = 1'b1;
    in_valid   = 1'b0;
    opcode     = OP_ADD;
    top_row    = '0;
    left_col   = '0;
    bottom_row = '0;
    right_col  = '0;
    add_value  = '0;
    out_stall  = 1'b0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty grid, corner cells, extremes, wrap, reversed boxes
    send_item(query_box(0, 0, 15, 15));
    send_item(add_at(0, 0, 32'h7fff_ffff));
    send_item(add_at(15, 15, 32'h8000_0000));
    send_item(add_at(0, 15, -1));
    send_item(add_at(15, 0, 1));
    send_item(query_box(0, 0, 15, 15));
    send_item(query_box(0, 0, 0, 0));
    send_item(query_box(15, 15, 15, 15));
    send_item(query_box(15, 0, 15, 0));
    send_item(add_at(0, 0, 32'h7fff_ffff));
    send_item(query_box(0, 0, 0, 0));
    send_item(query_box(15, 15, 0, 0));
    send_item(query_box(10, 2, 3, 12));
    send_item(add_at(7, 9, 12345));
    send_item(add_at(8, 8, -777));
    send_item(query_box(7, 8, 8, 9));
    send_item(query_box(0, 0, 15, 0));
    send_item(query_box(0, 0, 0, 15));
    send_item(add_at(5, 5, 0));
    send_item(query_box(5, 3, 5, 11));
    send_item(query_box(1, 1, 14, 14));
    send_item(query_box(0, 15, 15, 15));

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // long output hold-off while items keep coming
      if (n == 100) hold_req = 1'b1;
      if (n == 200) calm = 1'b1;
      if (n == 350) calm = 1'b0;
      // sender pause until every owed sum is back
      if (n == 400) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      send_item(random_item());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** fenwick_2d_region_sum: PASSED **");
    end else begin
      $display("** fenwick_2d_region_sum: FAILED **");
    end
    $finish;
  end
endmodule
